// ===== rtl/core/ufbd_pkg.sv =====
// Package for the fractional baud divisor search: constants, FSM state,
// channel payload structs and controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package ufbd_pkg;
  localparam int unsigned ClkW   = 28;
  localparam int unsigned BaudW  = 24;
  localparam int unsigned DivW   = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned WordW  = 32;
  localparam logic [ErrW-1:0] StartError = 17'd100000;
  localparam logic [3:0] MulMax = 4'd15;
  localparam logic [3:0] AddMax = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEMP_START,
    ST_TEMP_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ClkW-1:0] peripheral_clock_hz;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       port_index;
    logic [BaudW-1:0] baud_rate;
  } req_t;

  typedef struct packed {
    logic [2:0]      port_echo;
    logic            status;
    logic [DivW-1:0] divisor;
    logic [3:0]      mul_value;
    logic [3:0]      add_value;
    logic            found;
    logic [ErrW-1:0] best_error;
  } rsp_t;

  typedef struct packed {
    logic load;       // capture request, reset best
    logic temp_start; // divide m*base by m+a
    logic div_start;  // divide temp by baud
    logic rate_start; // divide temp by divisor
    logic eval;       // round/check divisor (after div)
    logic judge;      // compare error (after rate)
    logic advance;    // step to next pair
  } cmd_t;

  typedef struct packed {
    logic busy;       // divider busy
    logic cand_ok;    // rounded divisor in range
    logic zero_hit;   // judged error was zero and was taken
    logic last_pair;  // m=15, a=15
    logic skip;       // bad port or zero baud
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/ufbd_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface ufbd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uart_fractional_baud_divisor_search.sv =====
// Top level of the fractional baud divisor search.
// Depends on ufbd_pkg, ufbd_if, ufbd_ctrl, ufbd_datapath.
//
// A request carries a port index and a baud rate; the block tries every
// multiplier (1..15) and divide-add (0..15) pair, rounds a 16-bit divisor for
// each and returns the first pair with the lowest baud error, stopping early
// on an exact match. All arithmetic runs through one shared 32-bit serial
// divider that yields one quotient bit per cycle; each pair takes up to three
// divisions (the third only when the rounded divisor is in range), a search is
// much shorter when it stops on an early exact hit, and a request to an
// unavailable port or a zero baud rate skips the divisions. One request is in
// flight at a time; the result stays on the output until taken. Write the
// peripheral clock (reset 25 MHz) only while the block is idle.
`default_nettype none
module uart_fractional_baud_divisor_search #(
  parameter int unsigned PORT_COUNT = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufbd_if.sink      cfg,
  ufbd_if.sink      req,
  ufbd_if.source    rsp
);
  import ufbd_pkg::*;
  logic [ClkW-1:0] clk_hz_q;
  cmd_t  cmd;
  stat_t stat;

  // hold the configured peripheral clock
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clk_hz_q <= 28'd25000000;
    else if (cfg.valid) clk_hz_q <= cfg.data.peripheral_clock_hz;
  end

  ufbd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .cmd_o(cmd), .stat_i(stat)
  );

  ufbd_datapath #(.PORT_COUNT(PORT_COUNT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .clk_hz_i(clk_hz_q),
    .port_i(req.data.port_index), .baud_i(req.data.baud_rate),
    .port_o(rsp.data.port_echo), .status_o(rsp.data.status),
    .divisor_o(rsp.data.divisor), .mul_o(rsp.data.mul_value),
    .add_o(rsp.data.add_value), .found_o(rsp.data.found),
    .err_o(rsp.data.best_error)
  );
endmodule
`default_nettype wire

// ===== rtl/core/ufbd_divider.sv =====
// Radix-2 restoring divider, 32/32, one quotient bit a cycle.
// Depends on ufbd_pkg.
`default_nettype none
module ufbd_divider (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  logic                      start_i,
  input  wire  logic [ufbd_pkg::WordW-1:0] num_i,
  input  wire  logic [ufbd_pkg::WordW-1:0] den_i,
  output logic                            busy_o,
  output logic [ufbd_pkg::WordW-1:0]       quo_o,
  output logic [ufbd_pkg::WordW-1:0]       rem_o
);
  import ufbd_pkg::*;
  logic [5:0]       cnt_q, cnt_d;
  logic [WordW-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [WordW:0]   trial;

  always_comb begin
    cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    trial = {rem_q, quo_q[WordW-1]} - {1'b0, den_q};
    if (start_i) begin
      cnt_d = 6'd32; quo_d = num_i; rem_d = '0; den_d = den_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[WordW]) begin
        rem_d = trial[WordW-1:0];
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WordW-2:0], quo_q[WordW-1]};
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/ufbd_datapath.sv =====
// Datapath: pair counters, shared serial divider, best-candidate registers.
// Depends on ufbd_pkg and ufbd_divider.
`default_nettype none
module ufbd_datapath #(
  parameter int unsigned PORT_COUNT = 4
) (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  ufbd_pkg::cmd_t            cmd_i,
  output ufbd_pkg::stat_t                 stat_o,
  input  wire  logic [ufbd_pkg::ClkW-1:0]  clk_hz_i,
  input  wire  logic [2:0]                port_i,
  input  wire  logic [ufbd_pkg::BaudW-1:0] baud_i,
  output logic [2:0]                      port_o,
  output logic                            status_o,
  output logic [ufbd_pkg::DivW-1:0]        divisor_o,
  output logic [3:0]                      mul_o,
  output logic [3:0]                      add_o,
  output logic                            found_o,
  output logic [ufbd_pkg::ErrW-1:0]        err_o
);
  import ufbd_pkg::*;
  logic [2:0]       port_q;
  logic [BaudW-1:0] baud_q;
  logic [ClkW-5:0]  base_q;
  logic [3:0]       m_q, a_q, bm_q, ba_q;
  logic [DivW:0]    d_q;
  logic [WordW-1:0] temp_q;
  logic [DivW-1:0]  bd_q;
  logic [ErrW-1:0]  be_q;
  logic             bf_q, status_q;
  logic             start;
  logic [WordW-1:0] num, den, quo, rem;
  logic [WordW-1:0] dround, rate, err;
  logic             better;

  // m*base fits 32 bits (15 * 2^24)
  always_comb begin
    num = temp_q;
    den = {{(WordW-BaudW){1'b0}}, baud_q};
    if (cmd_i.temp_start) begin
      num = WordW'({4'd0, m_q} * {{(WordW-ClkW+4){1'b0}}, base_q});
      den = {{(WordW-5){1'b0}}, {1'b0, m_q} + {1'b0, a_q}};
    end else if (cmd_i.div_start) begin
      // temp is still on the divider output in this cycle
      num = quo;
    end else if (cmd_i.rate_start) begin
      den = {{(WordW-DivW-1){1'b0}}, d_q};
    end
  end
  assign start = cmd_i.temp_start | cmd_i.div_start | cmd_i.rate_start;

  ufbd_divider u_div (
    .clk_i, .rst_ni, .start_i(start), .num_i(num), .den_i(den),
    .busy_o(stat_o.busy), .quo_o(quo), .rem_o(rem)
  );

  always_comb begin
    dround = quo + ((rem > {9'd0, baud_q[BaudW-1:1]}) ? 32'd1 : 32'd0);
    rate   = quo;
    err    = (rate <= {8'd0, baud_q}) ? ({8'd0, baud_q} - rate)
                                      : (rate - {8'd0, baud_q});
    better = (err < {15'd0, be_q});
  end

  assign stat_o.cand_ok   = (d_q > 17'd2) && !d_q[DivW];
  assign stat_o.zero_hit  = better && (err == '0);
  assign stat_o.last_pair = (m_q == MulMax) && (a_q == AddMax);
  assign stat_o.skip      = status_q || (baud_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      port_q <= port_i; baud_q <= baud_i; base_q <= clk_hz_i[ClkW-1:4];
      status_q <= ({1'b0, port_i} >= 4'(PORT_COUNT));
      m_q <= 4'd1; a_q <= 4'd0;
      bd_q <= '0; bm_q <= 4'd1; ba_q <= 4'd0; bf_q <= 1'b0; be_q <= StartError;
    end
    if (cmd_i.temp_start == 1'b0 && cmd_i.eval) begin
      // quotient below 2^16 matters only; clamp overflow to out-of-range
      d_q <= (dround[WordW-1:DivW] != '0) ? {1'b1, 16'd0} : {1'b0, dround[DivW-1:0]};
    end
    if (cmd_i.div_start) temp_q <= quo;
    if (cmd_i.judge && better) begin
      bd_q <= d_q[DivW-1:0]; bm_q <= m_q; ba_q <= a_q;
      be_q <= err[ErrW-1:0]; bf_q <= 1'b1;
    end
    if (cmd_i.advance) begin
      if (a_q == AddMax) begin
        a_q <= 4'd0; m_q <= m_q + 4'd1;
      end else a_q <= a_q + 4'd1;
    end
  end

  assign port_o = port_q; assign status_o = status_q; assign divisor_o = bd_q;
  assign mul_o = bm_q; assign add_o = ba_q; assign found_o = bf_q; assign err_o = be_q;
endmodule
`default_nettype wire

// ===== rtl/core/ufbd_ctrl.sv =====
// Controller FSM sequencing the three divisions for each pair.
// Depends on ufbd_pkg.
`default_nettype none
module ufbd_ctrl (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire  logic            out_ready_i,
  output ufbd_pkg::cmd_t        cmd_o,
  input  wire  ufbd_pkg::stat_t stat_i
);
  import ufbd_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q; cmd_o = '0;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = ST_TEMP_START;
        end
      end
      ST_TEMP_START: begin
        if (stat_i.skip) state_d = ST_DONE;
        else begin
          cmd_o.temp_start = 1'b1; state_d = ST_TEMP_WAIT;
        end
      end
      ST_TEMP_WAIT: if (!stat_i.busy) state_d = ST_DIV_START;
      ST_DIV_START: begin
        // latch temp, divide it by the baud rate
        cmd_o.div_start = 1'b1; state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (!stat_i.busy) begin
        cmd_o.eval = 1'b1; state_d = ST_RATE_START;
      end
      ST_RATE_START: begin
        if (stat_i.cand_ok) begin
          cmd_o.rate_start = 1'b1; state_d = ST_RATE_WAIT;
        end else state_d = ST_NEXT;
      end
      ST_RATE_WAIT: if (!stat_i.busy) begin
        cmd_o.judge = 1'b1;
        state_d = stat_i.zero_hit ? ST_DONE : ST_NEXT;
      end
      ST_NEXT: begin
        if (stat_i.last_pair) state_d = ST_DONE;
        else begin
          cmd_o.advance = 1'b1; state_d = ST_TEMP_START;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/ufbd_checker.sv =====
// Port-level checker for the baud divisor search, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module ufbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        status,
  input wire logic        found,
  input wire logic [3:0]  mul_value,
  input wire logic [16:0] best_error
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready && rsp_valid)) else $error("request taken while result pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_bad_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status |-> !found && mul_value == 4'd1 && best_error == 17'd100000)
    else $error("bad port result not default");
  a_found_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && found |-> best_error < 17'd100000 && mul_value != 4'd0)
    else $error("found result with bad error");
endmodule

bind uart_fractional_baud_divisor_search ufbd_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.data.status), .found(rsp.data.found),
  .mul_value(rsp.data.mul_value), .best_error(rsp.data.best_error)
);
`default_nettype wire
